[hdl/erla_pkg.sv]
package erla_pkg;

	localparam int unsigned SEQ_W = 64;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned HND_W = 16;
	localparam int unsigned CNT_OUT_W = 3;
	localparam int unsigned IN_TDATA_W = 248;
	localparam int unsigned OUT_TDATA_W = 88;

	typedef enum logic [1:0] {
		OP_STORE  = 2'd0,
		OP_EXTRA  = 2'd1,
		OP_PACKET = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_ATTACHED = 3'd1,
		ST_NO_MATCH = 3'd2,
		ST_FULL     = 3'd3,
		ST_ENTRY    = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		EM_STORE   = 3'd0,
		EM_ATTACH  = 3'd1,
		EM_NOMATCH = 3'd2,
		EM_ENTRY   = 3'd3,
		EM_EMPTY   = 3'd4
	} emit_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [KEY_W-1:0] sensor;
		logic [KEY_W-1:0] number;
		logic [KEY_W-1:0] second;
		logic [HND_W-1:0] handle;
	} slot_t;

	typedef struct packed {
		logic  cap;
		logic  rd;
		logic  step;
		logic  q_hi;
		logic  q_lo;
		logic  q_init;
		logic  mod_step;
		logic  emit;
		emit_t kind;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic cnt_zero;
		logic cnt_one;
		logic match;
		logic mod_last;
	} stat_t;

endpackage

[hdl/erla_ctl.sv]
module erla_ctl
	import erla_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_ready,
	input  stat_t      stat,
	output cmd_t       cmd
);

	typedef enum logic [11:0] {
		S_IDLE    = 12'b000000000001,
		S_STORE   = 12'b000000000010,
		S_LK_RD   = 12'b000000000100,
		S_LK_CMP  = 12'b000000001000,
		S_ATT     = 12'b000000010000,
		S_NOMATCH = 12'b000000100000,
		S_Q_HI    = 12'b000001000000,
		S_Q_LO    = 12'b000010000000,
		S_Q_INIT  = 12'b000100000000,
		S_Q_MOD   = 12'b001000000000,
		S_Q_RD    = 12'b010000000000,
		S_Q_EMIT  = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   empty_q, empty_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		empty_d = empty_q;
		cmd = '0;
		cmd.kind = EM_STORE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					case (op_t'(in_op))
						OP_STORE: state_d = S_STORE;
						OP_EXTRA, OP_PACKET: state_d = S_LK_RD;
						default: state_d = S_Q_HI;
					endcase
				end
			end
			S_STORE: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EM_STORE;
					state_d = S_IDLE;
				end
			end
			S_LK_RD: begin
				if (stat.cnt_zero) begin
					state_d = S_NOMATCH;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_LK_CMP;
				end
			end
			S_LK_CMP: begin
				if (stat.match) begin
					state_d = S_ATT;
				end else begin
					cmd.step = 1'b1;
					state_d = S_LK_RD;
				end
			end
			S_ATT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EM_ATTACH;
					state_d = S_IDLE;
				end
			end
			S_NOMATCH: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = empty_q ? EM_EMPTY : EM_NOMATCH;
					empty_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			S_Q_HI: begin
				cmd.q_hi = 1'b1;
				state_d = S_Q_LO;
			end
			S_Q_LO: begin
				cmd.q_lo = 1'b1;
				state_d = S_Q_INIT;
			end
			S_Q_INIT: begin
				cmd.q_init = 1'b1;
				state_d = S_Q_MOD;
			end
			S_Q_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_last) begin
					state_d = S_Q_RD;
				end
			end
			S_Q_RD: begin
				if (stat.cnt_zero) begin
					empty_d = 1'b1;
					state_d = S_NOMATCH;
				end else begin
					cmd.rd = 1'b1;
					state_d = S_Q_EMIT;
				end
			end
			S_Q_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = EM_ENTRY;
					cmd.step = 1'b1;
					state_d = stat.cnt_one ? S_IDLE : S_Q_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			empty_q <= 1'b0;
		end else begin
			state_q <= state_d;
			empty_q <= empty_d;
		end
	end

endmodule

[hdl/erla_dp.sv]
module erla_dp
	import erla_pkg::*;
#(
	parameter int unsigned RING_ENTRIES      = 8192,
	parameter int unsigned LOOKBACK_DEPTH    = 16,
	parameter int unsigned QUERY_WINDOW      = 64,
	parameter int unsigned EXTRAS_PER_EVENT  = 4,
	parameter int unsigned PACKETS_PER_EVENT = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	input  logic [1:0]             in_op,
	input  logic [IN_TDATA_W-1:0]  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             out_user,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic                   out_last
);

	localparam int unsigned IW = $clog2(RING_ENTRIES);
	localparam int unsigned MAXW = (LOOKBACK_DEPTH > QUERY_WINDOW) ? LOOKBACK_DEPTH
		: QUERY_WINDOW;
	localparam int unsigned CNTW = $clog2(MAXW + 1);
	localparam int unsigned EW = $clog2(EXTRAS_PER_EVENT + 1);
	localparam int unsigned PW = $clog2(PACKETS_PER_EVENT + 1);
	localparam int unsigned DIG_W = 16;
	localparam int unsigned MX_W = 2 * DIG_W;
	localparam int unsigned NDIG = SEQ_W / DIG_W;
	localparam int unsigned BW = $clog2(NDIG);
	localparam int unsigned RK = MX_W + IW;
	localparam logic [MX_W:0] RECIP = (MX_W+1)'((64'd1 << RK) / 64'(RING_ENTRIES));

	slot_t              slot_mem [RING_ENTRIES];
	logic [EW+PW-1:0]   cnt_mem  [RING_ENTRIES];

	op_t                op_q;
	logic [KEY_W-1:0]   sen_q, num_q, sec_q;
	logic [HND_W-1:0]   hnd_q;
	logic               maxg_q, ming_q;
	logic [SEQ_W-1:0]   qmax_q, qmin_q;
	logic [SEQ_W-1:0]   ns_q, hi_q, lo_q, md_q;
	logic [IW-1:0]      wr_idx_q;
	logic [IW:0]        rem_q;
	logic [CNTW-1:0]    cnt_q;
	logic [BW-1:0]      bcnt_q;
	logic               mod_ph_q;
	logic [MX_W-1:0]    qe_q;
	slot_t              rd_slot_q;
	logic [EW+PW-1:0]   rd_cnt_q;

	logic               out_valid_q, out_last_q;
	status_t            out_status_q;
	logic [SEQ_W-1:0]   out_seq_q;
	logic [HND_W-1:0]   out_hnd_q;
	logic [2:0]         out_ex_q, out_pk_q;

	logic [IW-1:0]      rd_idx, rem_dec, wr_dec;
	logic [MX_W-1:0]    mod_x, mod_r;
	logic [2*MX_W:0]    mod_p;
	logic [IW:0]        mod_n;
	logic [EW-1:0]      rd_ex, ex_n;
	logic [PW-1:0]      rd_pk, pk_n;
	logic               room;
	logic [SEQ_W-1:0]   hi_d, lo_d, hi_w;
	slot_t              wr_slot;

	assign rd_idx  = rem_q[IW-1:0];
	assign rem_dec = (rd_idx == '0) ? IW'(RING_ENTRIES - 1) : rd_idx - IW'(1);
	assign wr_dec  = (wr_idx_q == '0) ? IW'(RING_ENTRIES - 1) : wr_idx_q - IW'(1);
	assign mod_x   = {DIG_W'(rem_q), md_q[SEQ_W-1 -: DIG_W]};
	assign mod_p   = (2*MX_W+1)'(mod_x) * (2*MX_W+1)'(RECIP);
	assign mod_r   = mod_x - MX_W'(qe_q * MX_W'(RING_ENTRIES));
	assign mod_n   = (mod_r >= MX_W'(RING_ENTRIES)) ? (IW+1)'(mod_r - MX_W'(RING_ENTRIES))
		: (IW+1)'(mod_r);

	assign rd_ex = rd_cnt_q[EW-1:0];
	assign rd_pk = rd_cnt_q[EW+PW-1:EW];
	always_comb begin
		ex_n = rd_ex;
		pk_n = rd_pk;
		if (op_q == OP_EXTRA) begin
			room = rd_ex < EW'(EXTRAS_PER_EVENT);
			if (room) ex_n = rd_ex + EW'(1);
		end else begin
			room = rd_pk < PW'(PACKETS_PER_EVENT);
			if (room) pk_n = rd_pk + PW'(1);
		end
	end

	assign hi_d = (maxg_q && (qmax_q < ns_q)) ? qmax_q : ns_q;
	assign hi_w = hi_q - SEQ_W'(QUERY_WINDOW);
	always_comb begin
		if (ming_q) begin
			if (qmin_q > hi_q) lo_d = hi_q;
			else if ((hi_q > SEQ_W'(QUERY_WINDOW)) && (qmin_q < hi_w)) lo_d = hi_w;
			else lo_d = qmin_q;
		end else begin
			lo_d = (hi_q > SEQ_W'(QUERY_WINDOW)) ? hi_w : '0;
		end
	end

	assign wr_slot = '{seq: ns_q, sensor: sen_q, number: num_q, second: sec_q,
		handle: hnd_q};

	assign stat.out_free = !out_valid_q || out_ready;
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.cnt_one  = (cnt_q == CNTW'(1));
	assign stat.match    = (rd_slot_q.sensor == sen_q) && (rd_slot_q.number == num_q)
		&& (rd_slot_q.second == sec_q);
	assign stat.mod_last = mod_ph_q && (bcnt_q == BW'(NDIG - 1));

	always_ff @(posedge clk) begin
		if (cmd.emit && (cmd.kind == EM_STORE)) begin
			slot_mem[wr_idx_q] <= wr_slot;
		end
		if (cmd.rd) begin
			rd_slot_q <= slot_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && (cmd.kind == EM_STORE)) begin
			cnt_mem[wr_idx_q] <= '0;
		end else if (cmd.emit && (cmd.kind == EM_ATTACH) && room) begin
			cnt_mem[rd_idx] <= {pk_n, ex_n};
		end
		if (cmd.rd) begin
			rd_cnt_q <= cnt_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q   <= op_t'(in_op);
			sen_q  <= in_data[31:0];
			num_q  <= in_data[63:32];
			sec_q  <= in_data[95:64];
			hnd_q  <= in_data[111:96];
			maxg_q <= in_data[112];
			qmax_q <= in_data[176:113];
			ming_q <= in_data[177];
			qmin_q <= in_data[241:178];
		end
		if (cmd.q_hi) hi_q <= hi_d;
		if (cmd.q_lo) lo_q <= lo_d;
		if (cmd.q_init) md_q <= hi_q - SEQ_W'(1);
		else if (cmd.mod_step && mod_ph_q) md_q <= {md_q[SEQ_W-DIG_W-1:0], DIG_W'(0)};
		if (cmd.mod_step && !mod_ph_q) qe_q <= MX_W'(mod_p >> RK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ns_q     <= '0;
			wr_idx_q <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
			bcnt_q   <= '0;
			mod_ph_q <= 1'b0;
		end else begin
			if (cmd.cap) begin
				rem_q <= {1'b0, wr_dec};
				cnt_q <= (ns_q < SEQ_W'(LOOKBACK_DEPTH)) ? CNTW'(ns_q) : CNTW'(LOOKBACK_DEPTH);
			end else if (cmd.q_init) begin
				rem_q    <= '0;
				bcnt_q   <= '0;
				mod_ph_q <= 1'b0;
				cnt_q    <= CNTW'(hi_q - lo_q);
			end else if (cmd.mod_step) begin
				mod_ph_q <= !mod_ph_q;
				if (mod_ph_q) begin
					rem_q  <= mod_n;
					bcnt_q <= bcnt_q + BW'(1);
				end
			end else if (cmd.step) begin
				rem_q <= {1'b0, rem_dec};
				cnt_q <= cnt_q - CNTW'(1);
			end
			if (cmd.emit && (cmd.kind == EM_STORE)) begin
				ns_q     <= ns_q + SEQ_W'(1);
				wr_idx_q <= (wr_idx_q == IW'(RING_ENTRIES - 1)) ? '0 : wr_idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_last_q <= (cmd.kind != EM_ENTRY) || stat.cnt_one;
			case (cmd.kind)
				EM_STORE: begin
					out_status_q <= ST_STORED;
					out_seq_q    <= ns_q;
					out_hnd_q    <= hnd_q;
					out_ex_q     <= '0;
					out_pk_q     <= '0;
				end
				EM_ATTACH: begin
					out_status_q <= room ? ST_ATTACHED : ST_FULL;
					out_seq_q    <= rd_slot_q.seq;
					out_hnd_q    <= rd_slot_q.handle;
					out_ex_q     <= CNT_OUT_W'(ex_n);
					out_pk_q     <= CNT_OUT_W'(pk_n);
				end
				EM_ENTRY: begin
					out_status_q <= ST_ENTRY;
					out_seq_q    <= rd_slot_q.seq;
					out_hnd_q    <= rd_slot_q.handle;
					out_ex_q     <= CNT_OUT_W'(rd_ex);
					out_pk_q     <= CNT_OUT_W'(rd_pk);
				end
				EM_NOMATCH: begin
					out_status_q <= ST_NO_MATCH;
					out_seq_q    <= '0;
					out_hnd_q    <= '0;
					out_ex_q     <= '0;
					out_pk_q     <= '0;
				end
				default: begin
					out_status_q <= ST_EMPTY;
					out_seq_q    <= '0;
					out_hnd_q    <= '0;
					out_ex_q     <= '0;
					out_pk_q     <= '0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_user  = out_status_q;
	assign out_last  = out_last_q;
	assign out_data  = {2'b00, out_pk_q, out_ex_q, out_hnd_q, out_seq_q};

endmodule

[hdl/event_ring_with_lookback_attach_top.sv]
// channel   dir  tdata                                              tuser      tlast
// s_axis    in   sensor,number,second,handle,max_g,max,min_g,min   operation  -
// m_axis    out  sequence_id,event_handle,extras,packets           status     last
//
// Store writes one slot at the ring pointer. Attach reads lookback slots one at a time (up to
// LOOKBACK_DEPTH, one slot memory read port) until a match or the slots run out.
// Query clamps the window and reduces its top sequence to a ring index, one 16-bit
// digit at a time, then reads and reports each entry in turn.
// arst_n clears the sequence counter, ring pointer and control; no clearing pass.
// A stalled m_axis holds the current beat; the sequencer waits at each emit.
module event_ring_with_lookback_attach_top
	import erla_pkg::*;
#(
	parameter int unsigned RING_ENTRIES      = 8192,
	parameter int unsigned LOOKBACK_DEPTH    = 16,
	parameter int unsigned QUERY_WINDOW      = 64,
	parameter int unsigned EXTRAS_PER_EVENT  = 4,
	parameter int unsigned PACKETS_PER_EVENT = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// sensor, event no., seconds stamp, record_handle, max_given, query_max,
	// min_given, query_min
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// operation
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// sequence_id, event_handle, extras_attached, packets_attached
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status
	output logic [2:0]             m_axis_tuser,
	output logic                   m_axis_tlast
);

	cmd_t  cmd;
	stat_t stat;

	erla_ctl u_ctl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	erla_dp #(
		.RING_ENTRIES      (RING_ENTRIES),
		.LOOKBACK_DEPTH    (LOOKBACK_DEPTH),
		.QUERY_WINDOW      (QUERY_WINDOW),
		.EXTRAS_PER_EVENT  (EXTRAS_PER_EVENT),
		.PACKETS_PER_EVENT (PACKETS_PER_EVENT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_user  (m_axis_tuser),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

[verif/event_ring_with_lookback_attach_checker.sv]
module event_ring_with_lookback_attach_checker
	import erla_pkg::*;
#(
	parameter int unsigned RING_ENTRIES      = 8192,
	parameter int unsigned LOOKBACK_DEPTH    = 16,
	parameter int unsigned QUERY_WINDOW      = 64,
	parameter int unsigned EXTRAS_PER_EVENT  = 4,
	parameter int unsigned PACKETS_PER_EVENT = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic [1:0]             s_axis_tuser,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic [2:0]             m_axis_tuser,
	input  logic                   m_axis_tlast,
	output int                     fail_count,
	output int                     beats_owed
);

	typedef struct {
		status_t     status;
		logic [63:0] seq;
		logic [15:0] hnd;
		logic [2:0]  extras;
		logic [2:0]  packets;
		logic        last;
	} ring_beat_t;

	ring_beat_t  owed_q[$];
	int          fails = 0;
	logic [63:0] next_seq = '0;
	logic        r_valid   [RING_ENTRIES];
	logic [63:0] r_seq     [RING_ENTRIES];
	logic [31:0] r_sensor  [RING_ENTRIES];
	logic [31:0] r_number  [RING_ENTRIES];
	logic [31:0] r_second  [RING_ENTRIES];
	logic [15:0] r_handle  [RING_ENTRIES];
	logic [2:0]  r_extras  [RING_ENTRIES];
	logic [2:0]  r_packets [RING_ENTRIES];

	initial begin
		for (int i = 0; i < RING_ENTRIES; i++) begin
			r_valid[i] = 1'b0;
			r_extras[i] = '0;
			r_packets[i] = '0;
		end
	end

	assign fail_count = fails;
	assign beats_owed = owed_q.size();

	function automatic void owe(status_t st, logic [63:0] sq, logic [15:0] h,
			logic [2:0] ex, logic [2:0] pk, logic lst);
		ring_beat_t b;
		b.status = st;
		b.seq = sq;
		b.hnd = h;
		b.extras = ex;
		b.packets = pk;
		b.last = lst;
		owed_q.push_back(b);
	endfunction

	function automatic int find_recent(logic [31:0] sen, logic [31:0] num,
			logic [31:0] sec);
		int s;
		for (int h = 0; h < LOOKBACK_DEPTH; h++) begin
			if (next_seq == 64'(h))
				return -1;
			s = int'((next_seq - 64'(h) - 64'd1) % RING_ENTRIES);
			if (!r_valid[s])
				return -1;
			if (r_sensor[s] == sen && r_number[s] == num && r_second[s] == sec)
				return s;
		end
		return -1;
	endfunction

	function automatic void predict_ring(op_t op, logic [IN_TDATA_W-1:0] d);
		logic [31:0] sen, num, sec;
		logic [15:0] hnd;
		logic        max_g, min_g;
		logic [63:0] qmax, qmin, hi, lo, idx;
		int          s, n;
		status_t     st;
		sen = d[31:0];
		num = d[63:32];
		sec = d[95:64];
		hnd = d[111:96];
		max_g = d[112];
		qmax = d[176:113];
		min_g = d[177];
		qmin = d[241:178];
		case (op)
			OP_STORE: begin
				s = int'(next_seq % RING_ENTRIES);
				r_valid[s] = 1'b1;
				r_seq[s] = next_seq;
				r_sensor[s] = sen;
				r_number[s] = num;
				r_second[s] = sec;
				r_handle[s] = hnd;
				r_extras[s] = '0;
				r_packets[s] = '0;
				owe(ST_STORED, next_seq, hnd, 3'd0, 3'd0, 1'b1);
				next_seq++;
			end
			OP_EXTRA, OP_PACKET: begin
				s = find_recent(sen, num, sec);
				if (s < 0) begin
					owe(ST_NO_MATCH, '0, '0, '0, '0, 1'b1);
				end else begin
					st = ST_FULL;
					if (op == OP_EXTRA && r_extras[s] < EXTRAS_PER_EVENT) begin
						r_extras[s]++;
						st = ST_ATTACHED;
					end
					if (op == OP_PACKET && r_packets[s] < PACKETS_PER_EVENT) begin
						r_packets[s]++;
						st = ST_ATTACHED;
					end
					owe(st, r_seq[s], r_handle[s], r_extras[s], r_packets[s], 1'b1);
				end
			end
			default: begin
				n = 0;
				if (next_seq != 0) begin
					hi = next_seq;
					if (max_g && qmax < hi)
						hi = qmax;
					if (min_g) begin
						lo = qmin;
						if (lo > hi)
							lo = hi;
						else if (hi > QUERY_WINDOW && lo < hi - QUERY_WINDOW)
							lo = hi - QUERY_WINDOW;
					end else begin
						lo = (hi > QUERY_WINDOW) ? hi - QUERY_WINDOW : 64'd0;
					end
					for (idx = hi; idx > lo && n < QUERY_WINDOW; idx--) begin
						s = int'((idx - 64'd1) % RING_ENTRIES);
						if (r_valid[s]) begin
							owe(ST_ENTRY, r_seq[s], r_handle[s], r_extras[s],
								r_packets[s], 1'b0);
							n++;
						end
					end
				end
				if (n == 0)
					owe(ST_EMPTY, '0, '0, '0, '0, 1'b1);
				else
					owed_q[$].last = 1'b1;
			end
		endcase
	endfunction

	always @(posedge clk) begin
		ring_beat_t b;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_ring(op_t'(s_axis_tuser), s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (owed_q.size() == 0) begin
					$error("unexpected beat: status %0d seq %0d", m_axis_tuser,
						m_axis_tdata[63:0]);
					fails++;
				end else begin
					b = owed_q.pop_front();
					if (m_axis_tuser != b.status) begin
						$error("status: expected %0d, got %0d", b.status, m_axis_tuser);
						fails++;
					end
					if (m_axis_tdata[63:0] != b.seq) begin
						$error("sequence_id: expected %0d, got %0d", b.seq,
							m_axis_tdata[63:0]);
						fails++;
					end
					if (m_axis_tdata[79:64] != b.hnd) begin
						$error("event_handle: expected %0d, got %0d", b.hnd,
							m_axis_tdata[79:64]);
						fails++;
					end
					if (m_axis_tdata[82:80] != b.extras) begin
						$error("extras_attached: expected %0d, got %0d", b.extras,
							m_axis_tdata[82:80]);
						fails++;
					end
					if (m_axis_tdata[85:83] != b.packets) begin
						$error("packets_attached: expected %0d, got %0d", b.packets,
							m_axis_tdata[85:83]);
						fails++;
					end
					if (m_axis_tlast != b.last) begin
						$error("last: expected %0d, got %0d", b.last, m_axis_tlast);
						fails++;
					end
				end
			end
		end
	end

endmodule

[verif/event_ring_with_lookback_attach_top_tb.sv]
module event_ring_with_lookback_attach_top_tb;
	import erla_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]             s_axis_tuser = OP_STORE;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [2:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	int fail_count, beats_owed;
	int idle_pct = 0;
	int stall_pct = 0;
	int sent = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int cycles = 0;
	int stored = 0;
	logic [31:0] key_sen[$], key_num[$], key_sec[$];

	always #4 clk = ~clk;

	event_ring_with_lookback_attach_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	event_ring_with_lookback_attach_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count), .beats_owed(beats_owed)
	);

	// hold off the receiver once for a long stretch to fill the block
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!hold_done && sent == 40) begin
			hold_done <= 1'b1;
			hold_left <= 3000;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_beat(op_t op, logic [31:0] sen, logic [31:0] num,
			logic [31:0] sec, logic [15:0] hnd, logic max_g, logic [63:0] qmax,
			logic min_g, logic [63:0] qmin);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {6'd0, qmin, min_g, qmax, max_g, hnd, sec, num, sen};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sent++;
		if (op == OP_STORE) begin
			stored++;
			key_sen.push_back(sen);
			key_num.push_back(num);
			key_sec.push_back(sec);
		end
	endtask

	task automatic send_random();
		int          pick, k;
		logic [31:0] sen, num, sec;
		logic [63:0] qmax, qmin;
		pick = $urandom_range(99);
		if ($urandom_range(1)) begin
			sen = $urandom_range(3);
			num = $urandom_range(3);
			sec = $urandom_range(1);
		end else begin
			sen = $urandom;
			num = $urandom;
			sec = $urandom;
		end
		if (pick < 40) begin
			send_beat(OP_STORE, sen, num, sec, 16'($urandom), 1'($urandom_range(1)),
				rand64(), 1'($urandom_range(1)), rand64());
		end else if (pick < 80) begin
			if (stored > 0 && $urandom_range(99) < 85) begin
				k = stored - 1 - $urandom_range((stored < 22) ? stored - 1 : 21);
				sen = key_sen[k];
				num = key_num[k];
				sec = key_sec[k];
			end
			send_beat((pick < 60) ? OP_EXTRA : OP_PACKET, sen, num, sec, 16'($urandom),
				1'($urandom_range(1)), rand64(), 1'($urandom_range(1)), rand64());
		end else begin
			qmax = $urandom_range(3) == 0 ? rand64() : 64'($urandom_range(stored + 4));
			qmin = $urandom_range(3) == 0 ? rand64() : 64'($urandom_range(stored + 4));
			send_beat(OP_QUERY, $urandom, $urandom, $urandom, 16'($urandom),
				1'($urandom_range(1)), qmax, 1'($urandom_range(1)), qmin);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_beat(OP_QUERY, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0);
		send_beat(OP_EXTRA, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0);
		send_beat(OP_STORE, '0, '0, '0, '0, 1'b1, '1, 1'b1, '1);
		send_beat(OP_STORE, '1, '1, '1, '1, 1'b0, '0, 1'b0, '0);
		for (int i = 0; i < 5; i++)
			send_beat(OP_EXTRA, '1, '1, '1, 16'(i), 1'b0, '0, 1'b0, '0);
		for (int i = 0; i < 5; i++)
			send_beat(OP_PACKET, '0, '0, '0, 16'(i), 1'b1, '1, 1'b1, '1);
		send_beat(OP_PACKET, '1, '0, '1, '1, 1'b0, '0, 1'b0, '0);
		send_beat(OP_STORE, '1, '1, '1, 16'h5a5a, 1'b0, '0, 1'b0, '0);
		send_beat(OP_EXTRA, '1, '1, '1, '0, 1'b0, '0, 1'b0, '0);
		send_beat(OP_QUERY, '0, '0, '0, '0, 1'b1, '1, 1'b1, '1);
		send_beat(OP_QUERY, '0, '0, '0, '0, 1'b1, '0, 1'b0, '0);
		send_beat(OP_QUERY, '0, '0, '0, '0, 1'b1, 64'd2, 1'b1, 64'd1);
		send_beat(OP_QUERY, '1, '1, '1, '1, 1'b0, '1, 1'b1, '0);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 52 : 21) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 52 : 21) : 0;
			for (int i = 0; i < 75; i++)
				send_random();
		end
		s_axis_tvalid <= 1'b0;
		while (beats_owed != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && beats_owed == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
